// File: rtl/cle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cle_pkg
// shared types and constants for the cursor line editor
// ----------------------------------------------------------------------------
package cle_pkg;

    // keystroke bytes with a special meaning
    localparam logic [7:0] KEY_LEFT  = 8'h3C;
    localparam logic [7:0] KEY_RIGHT = 8'h3E;
    localparam logic [7:0] KEY_BACK  = 8'h2D;

    // request classes handed from front end to back end
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BACK   = 3'd3;
    localparam logic [2:0] OP_EMIT   = 3'd4;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
    } cmd_t;

endpackage
`default_nettype wire

// File: rtl/cle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cle_front
// accepts requests and classifies them into commands for the queue
// ----------------------------------------------------------------------------
module cle_front (
    input  wire logic          in_valid,
    input  wire logic          req_type,
    input  wire logic [7:0]    key_code,
    input  wire logic          q_full,
    output logic               in_stall,
    output logic               push,
    output cle_pkg::cmd_t      cmd
);
    import cle_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.ch = key_code;
        priority if (req_type)
            cmd.op = OP_EMIT;
        else if (key_code == KEY_LEFT)
            cmd.op = OP_LEFT;
        else if (key_code == KEY_RIGHT)
            cmd.op = OP_RIGHT;
        else if (key_code == KEY_BACK)
            cmd.op = OP_BACK;
        else
            cmd.op = OP_INSERT;
    end

endmodule
`default_nettype wire

// File: rtl/cle_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cle_queue
// small command fifo between front end and back end
// ----------------------------------------------------------------------------
module cle_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire cle_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               q_valid,
    output cle_pkg::cmd_t      q_cmd
);
    import cle_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg;
    logic [QUEUE_AW:0]   wr_ptr_next;
    logic [QUEUE_AW:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]   rd_ptr_next;

    assign full = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW])
               && (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign q_valid = (wr_ptr_reg != rd_ptr_reg);
    assign q_cmd   = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_cmd;
    end

endmodule
`default_nettype wire

// File: rtl/cle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cle_back
// executes commands on the two cursor stacks and streams out finished lines
// ----------------------------------------------------------------------------
module cle_back #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire cle_pkg::cmd_t cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_char,
    output logic               last_char,
    output logic               line_empty,
    output logic               overflow
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_DEPTH + 1);
    localparam int AW = $clog2(LINE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOVE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // stores
    logic [7:0]     before_mem [LINE_DEPTH];
    logic [7:0]     after_mem  [LINE_DEPTH];
    logic [7:0]     before_rdata_reg;
    logic [7:0]     after_rdata_reg;
    logic           before_we;
    logic [AW-1:0]  before_waddr;
    logic [7:0]     before_wdata;
    logic           before_re;
    logic [AW-1:0]  before_raddr;
    logic           after_we;
    logic [AW-1:0]  after_waddr;
    logic [7:0]     after_wdata;
    logic           after_re;
    logic [AW-1:0]  after_raddr;

    // control state
    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  bc_reg, bc_next;
    logic [CW-1:0]  ac_reg, ac_next;
    logic           ovf_reg, ovf_next;
    logic           dir_left_reg, dir_left_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           rd_pend_reg, rd_pend_next;
    logic           rd_sel_reg, rd_sel_next;
    logic           out_valid_reg, out_valid_next;

    // output payload
    logic [7:0]     out_char_reg;
    logic           last_char_reg;
    logic           line_empty_reg;
    logic           overflow_reg;

    logic [CW:0]    total_w;
    logic [CW-1:0]  bc_dec;
    logic [CW-1:0]  ac_dec;
    logic [CW-1:0]  rd_idx;
    logic [CW-1:0]  after_idx;
    logic           issue;
    logic           out_free;
    logic           out_load;
    logic [7:0]     load_char;
    logic           load_last;
    logic           load_empty;
    logic           is_last;
    logic [7:0]     rdata;

    assign total_w   = {1'b0, bc_reg} + {1'b0, ac_reg};
    assign bc_dec    = bc_reg - CW'(1);
    assign ac_dec    = ac_reg - CW'(1);
    assign after_idx = CW'(total_w - (CW+1)'(1) - {1'b0, rd_idx});
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_last   = (({1'b0, k_reg} + (CW+1)'(1)) == total_w);
    assign rdata     = rd_sel_reg ? after_rdata_reg : before_rdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        bc_next       = bc_reg;
        ac_next       = ac_reg;
        ovf_next      = ovf_reg;
        dir_left_next = dir_left_reg;
        k_next        = k_reg;
        rd_pend_next  = rd_pend_reg;
        rd_sel_next   = rd_sel_reg;
        pop           = 1'b0;
        issue         = 1'b0;
        rd_idx        = k_reg;
        out_load      = 1'b0;
        load_char     = 8'd0;
        load_last     = 1'b0;
        load_empty    = 1'b0;
        before_we     = 1'b0;
        before_waddr  = '0;
        before_wdata  = 8'd0;
        before_re     = 1'b0;
        before_raddr  = '0;
        after_we      = 1'b0;
        after_waddr   = '0;
        after_wdata   = 8'd0;
        after_re      = 1'b0;
        after_raddr   = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pop = 1'b1;
                    unique case (cmd.op)
                        OP_LEFT:
                        begin
                            if (bc_reg != '0 && ac_reg < CW'(LINE_DEPTH))
                            begin
                                before_re     = 1'b1;
                                before_raddr  = bc_dec[AW-1:0];
                                bc_next       = bc_dec;
                                dir_left_next = 1'b1;
                                state_next    = ST_MOVE;
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (ac_reg != '0 && bc_reg < CW'(LINE_DEPTH))
                            begin
                                after_re      = 1'b1;
                                after_raddr   = ac_dec[AW-1:0];
                                ac_next       = ac_dec;
                                dir_left_next = 1'b0;
                                state_next    = ST_MOVE;
                            end
                        end
                        OP_BACK:
                        begin
                            if (bc_reg != '0)
                                bc_next = bc_dec;
                        end
                        OP_EMIT:
                        begin
                            k_next       = '0;
                            rd_pend_next = 1'b0;
                            state_next   = ST_EMIT;
                        end
                        OP_INSERT:
                        begin
                            if (total_w >= (CW+1)'(LINE_DEPTH))
                                ovf_next = 1'b1;
                            else
                            begin
                                before_we    = 1'b1;
                                before_waddr = bc_reg[AW-1:0];
                                before_wdata = cmd.ch;
                                bc_next      = bc_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MOVE:
            begin
                // second half of a cursor move: push the popped character
                if (dir_left_reg)
                begin
                    after_we    = 1'b1;
                    after_waddr = ac_reg[AW-1:0];
                    after_wdata = before_rdata_reg;
                    ac_next     = ac_reg + CW'(1);
                end
                else
                begin
                    before_we    = 1'b1;
                    before_waddr = bc_reg[AW-1:0];
                    before_wdata = after_rdata_reg;
                    bc_next      = bc_reg + CW'(1);
                end
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (total_w == '0)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        load_last  = 1'b1;
                        load_empty = 1'b1;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
                else if (!rd_pend_reg)
                begin
                    issue        = 1'b1;
                    rd_pend_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_load  = 1'b1;
                    load_char = rdata;
                    load_last = is_last;
                    if (is_last)
                    begin
                        bc_next      = '0;
                        ac_next      = '0;
                        ovf_next     = 1'b0;
                        rd_pend_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        // fetch the next character while this one goes out
                        k_next = k_reg + CW'(1);
                        rd_idx = k_reg + CW'(1);
                        issue  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue)
        begin
            if (rd_idx < bc_reg)
            begin
                before_re    = 1'b1;
                before_raddr = rd_idx[AW-1:0];
                rd_sel_next  = 1'b0;
            end
            else
            begin
                after_re    = 1'b1;
                after_raddr = after_idx[AW-1:0];
                rd_sel_next = 1'b1;
            end
        end
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bc_reg        <= '0;
            ac_reg        <= '0;
            ovf_reg       <= 1'b0;
            dir_left_reg  <= 1'b0;
            k_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            rd_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            ac_reg        <= ac_next;
            ovf_reg       <= ovf_next;
            dir_left_reg  <= dir_left_next;
            k_reg         <= k_next;
            rd_pend_reg   <= rd_pend_next;
            rd_sel_reg    <= rd_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg   <= load_char;
            last_char_reg  <= load_last;
            line_empty_reg <= load_empty;
            overflow_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (before_we)
            before_mem[before_waddr] <= before_wdata;
        if (before_re)
            before_rdata_reg <= before_mem[before_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (after_we)
            after_mem[after_waddr] <= after_wdata;
        if (after_re)
            after_rdata_reg <= after_mem[after_raddr];
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_char_reg;
    assign line_empty = line_empty_reg;
    assign overflow   = overflow_reg;

    // the two stacks together never hold more than a line
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_w <= (CW+1)'(LINE_DEPTH))
        else $error("cursor stacks exceed line depth");

    // an empty-line result is always the last one and carries no character
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_empty_reg) |-> (last_char_reg && out_char_reg == 8'd0))
        else $error("empty line result malformed");

    // sending the last character clears the line
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && load_last) |=> (bc_reg == '0 && ac_reg == '0 && !ovf_reg))
        else $error("line not cleared after end of line");

    // a move write phase only follows a decode cycle
    a_move_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> ($past(state_reg) == ST_IDLE))
        else $error("move phase entered from wrong state");

endmodule
`default_nettype wire

// File: rtl/cursor_line_editor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_line_editor
// keystroke line editor kept as two stacks around the cursor
// ----------------------------------------------------------------------------
// intake: a request enters the 4-entry command queue; the back end handles an
//   insert or backspace in its idle state and a cursor move in the idle and
//   move states (store read, then write of the other store)
// throughput: 1 request per cycle into the queue unless full; end of line
//   streams a character per cycle unless stalled, an empty line gives one result
// reset: clears queue, counts, overflow flag and output valid; the stores are
//   not cleared, only entries below the counts are ever read
module cursor_line_editor #(
    parameter int LINE_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // request channel
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          req_type,
    input  wire logic [7:0]    key_code,
    // result channel
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_char,
    output logic               last_char,
    output logic               line_empty,
    output logic               overflow
);
    import cle_pkg::*;

    // front end to queue
    logic   q_push;
    cmd_t   front_cmd;
    logic   q_full;

    // queue to back end
    logic   q_valid;
    cmd_t   q_cmd;
    logic   q_pop;

    // front end decodes the keystroke and pushes while there is room
    cle_front u_front (
        .in_valid (in_valid),
        .req_type (req_type),
        .key_code (key_code),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    // decouples request intake from stack work and line readout
    cle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // back end owns both stores, the counts and the output register
    cle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_char  (last_char),
        .line_empty (line_empty),
        .overflow   (overflow)
    );

endmodule
`default_nettype wire
